### rtl/rsmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsmp_pkg: shared types and constants of the 1-D box-average resampler
// Field widths, register indexes and the command word passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package rsmp_pkg;

   // sizes and positions are 13-bit counts
   localparam int POS_W = 13;
   localparam int SAMPLE_W = 16;
   // a group sum of up to 8191 samples
   localparam int SUM_W = SAMPLE_W + POS_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_IN_SIZE = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_SIZE = CSR_ADDR_W'(1);

   localparam logic [POS_W-1:0] RESET_SIZE = POS_W'(256);

   // command queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // avg = 1: divide sum by len and emit one result
   // avg = 0: repeat sum[SAMPLE_W-1:0] len times
   typedef struct packed {
      logic             avg;
      logic             last;
      logic             err;
      logic [SUM_W-1:0] sum;
      logic [POS_W-1:0] len;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage
`default_nettype wire

### rtl/rsmp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsmp_queue: short command queue
// Register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rsmp_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  rsmp_pkg::cmd_type            push_cmd,
   input  wire logic                    pop,
   output rsmp_pkg::cmd_type            pop_cmd,
   output rsmp_pkg::queue_stat_type     stat
);
   import rsmp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type entries_ff [QUEUE_DEPTH];
   cmd_type entries_in [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // store on push, advance pointers, track fill
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      entries_ff <= entries_in;
   end

   assign pop_cmd = entries_ff[rd_ptr_ff];
   assign stat.full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule
`default_nettype wire

### rtl/rsmp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsmp_front: size registers, ratio divider and item classification
// Holds the pass state, decides for each item whether it closes a group
// (shrink) or how many copies it gets (grow), and issues commands.
// ----------------------------------------------------------------------------
module rsmp_front #(
   parameter int MAX_LEN = 4096,
   parameter int MAX_REPEAT = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [rsmp_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  wire logic [rsmp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                req_push,
   input  wire logic [rsmp_pkg::SAMPLE_W-1:0]       req_sample,
   output logic                                     req_full,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output rsmp_pkg::cmd_type                        q_cmd
);
   import rsmp_pkg::*;

   localparam int STEP_W = $clog2(POS_W + 1);
   localparam logic [POS_W:0] REPEAT_CAP = (POS_W + 1)'(MAX_REPEAT);

   typedef enum logic [1:0] {
      RATIO_LOAD,
      RATIO_RUN,
      RATIO_DONE
   } ratio_state_type;

   function automatic logic [POS_W-1:0] eff_size(input logic [POS_W-1:0] v);
      logic [POS_W-1:0] e;
      if (v == '0) begin
         e = POS_W'(1);
      end else if (32'(v) > MAX_LEN) begin
         e = POS_W'(MAX_LEN);
      end else begin
         e = v;
      end
      return e;
   endfunction

   ratio_state_type ratio_state_ff, ratio_state_in;
   logic [POS_W-1:0] in_size_ff, in_size_in;
   logic [POS_W-1:0] out_size_ff, out_size_in;
   logic             shrink_ff, shrink_in;
   logic [POS_W-1:0] dvd_ff, dvd_in;    // dividend, then the ratio
   logic [POS_W-1:0] dvs_ff, dvs_in;    // divisor
   logic [POS_W-1:0] prem_ff, prem_in;  // partial remainder, then the remainder
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [POS_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] acc_ff, acc_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic [POS_W-1:0] ni, no;
   logic             csr_hit;
   logic [POS_W:0]   trial, trial_diff;
   logic             trial_ge;
   logic             accept, last;
   logic [POS_W:0]   nacc, nacc_diff, len, fill_new;
   logic             extra, emit, capped;
   logic [SUM_W-1:0] sum_new;

   assign ni = eff_size(in_size_ff);
   assign no = eff_size(out_size_ff);
   assign csr_hit = csr_valid && (csr_index == CSR_IN_SIZE || csr_index == CSR_OUT_SIZE);

   assign req_full = (ratio_state_ff != RATIO_DONE) || q_full;
   assign accept = req_push && !req_full;

   // one restoring division step for the ratio
   assign trial = {prem_ff, dvd_ff[POS_W-1]};
   assign trial_ge = (trial >= {1'b0, dvs_ff});
   assign trial_diff = trial - {1'b0, dvs_ff};

   // classify the item against the current group or run
   assign last = ({1'b0, pos_ff} + (POS_W + 1)'(1)) >= {1'b0, ni};
   assign nacc = {1'b0, acc_ff} + {1'b0, prem_ff};
   assign extra = (nacc >= {1'b0, dvs_ff});
   assign nacc_diff = nacc - {1'b0, dvs_ff};
   assign len = {1'b0, dvd_ff} + (POS_W + 1)'(extra);
   assign sum_new = sum_ff + SUM_W'(req_sample);
   assign fill_new = {1'b0, fill_ff} + (POS_W + 1)'(1);
   assign emit = (fill_new >= len) || last;
   assign capped = (len > REPEAT_CAP);

   always_comb begin
      q_cmd.avg = shrink_ff;
      q_cmd.last = last;
      if (shrink_ff) begin
         q_cmd.err = 1'b0;
         q_cmd.sum = sum_new;
         q_cmd.len = fill_new[POS_W-1:0];
      end else begin
         q_cmd.err = capped;
         q_cmd.sum = SUM_W'(req_sample);
         q_cmd.len = capped ? REPEAT_CAP[POS_W-1:0] : len[POS_W-1:0];
      end
   end

   assign q_push = accept && (!shrink_ff || emit);

   always_comb begin
      ratio_state_in = ratio_state_ff;
      in_size_in = in_size_ff;
      out_size_in = out_size_ff;
      shrink_in = shrink_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      prem_in = prem_ff;
      step_in = step_ff;
      sum_in = sum_ff;
      fill_in = fill_ff;
      acc_in = acc_ff;
      pos_in = pos_ff;

      // run the ratio divider after reset or a size write
      case (ratio_state_ff)
         RATIO_LOAD: begin
            shrink_in = (ni > no);
            dvd_in = (ni > no) ? ni : no;
            dvs_in = (ni > no) ? no : ni;
            prem_in = '0;
            step_in = STEP_W'(POS_W);
            ratio_state_in = RATIO_RUN;
         end
         RATIO_RUN: begin
            prem_in = trial_ge ? trial_diff[POS_W-1:0] : trial[POS_W-1:0];
            dvd_in = {dvd_ff[POS_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               ratio_state_in = RATIO_DONE;
            end
         end
         RATIO_DONE: begin
            ratio_state_in = RATIO_DONE;
         end
         default: begin
            ratio_state_in = RATIO_LOAD;
         end
      endcase

      // accumulate the group, advance the remainder, wrap at pass end
      if (accept) begin
         if (shrink_ff) begin
            if (emit) begin
               sum_in = '0;
               fill_in = '0;
               acc_in = extra ? nacc_diff[POS_W-1:0] : nacc[POS_W-1:0];
            end else begin
               sum_in = sum_new;
               fill_in = fill_new[POS_W-1:0];
            end
         end else begin
            acc_in = extra ? nacc_diff[POS_W-1:0] : nacc[POS_W-1:0];
         end
         if (last) begin
            sum_in = '0;
            fill_in = '0;
            acc_in = '0;
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end

      // a size write restarts the pass and the ratio
      if (csr_hit) begin
         if (csr_index == CSR_IN_SIZE) begin
            in_size_in = csr_wdata[POS_W-1:0];
         end else begin
            out_size_in = csr_wdata[POS_W-1:0];
         end
         sum_in = '0;
         fill_in = '0;
         acc_in = '0;
         pos_in = '0;
         ratio_state_in = RATIO_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_state_ff <= RATIO_LOAD;
         in_size_ff <= RESET_SIZE;
         out_size_ff <= RESET_SIZE;
         sum_ff <= '0;
         fill_ff <= '0;
         acc_ff <= '0;
         pos_ff <= '0;
      end else begin
         ratio_state_ff <= ratio_state_in;
         in_size_ff <= in_size_in;
         out_size_ff <= out_size_in;
         sum_ff <= sum_in;
         fill_ff <= fill_in;
         acc_ff <= acc_in;
         pos_ff <= pos_in;
      end
      shrink_ff <= shrink_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      prem_ff <= prem_in;
      step_ff <= step_in;
   end

endmodule
`default_nettype wire

### rtl/rsmp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsmp_back: average divider, repeater and result register
// Carries out queued commands: divides a group sum by its fill count, or
// emits a run of copies, one result per free output slot.
// ----------------------------------------------------------------------------
module rsmp_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  rsmp_pkg::queue_stat_type             q_stat,
   input  rsmp_pkg::cmd_type                    q_cmd,
   output logic                                 q_pop,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_empty,
   output logic [rsmp_pkg::SAMPLE_W-1:0]        rsp_value,
   output logic                                 rsp_run_end,
   output logic                                 rsp_pass_end,
   output logic                                 rsp_error
);
   import rsmp_pkg::*;

   localparam int STEP_W = $clog2(SAMPLE_W + 1);

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_EMIT,
      BACK_REP
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [POS_W-1:0]    prem_ff, prem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;     // dividend bits, then quotient; copy value
   logic [POS_W-1:0]    dvs_ff, dvs_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [POS_W-1:0]    left_ff, left_in;
   logic                last_ff, last_in;
   logic                err_ff, err_in;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic                run_end_ff, run_end_in;
   logic                pass_end_ff, pass_end_in;
   logic                error_ff, error_in;

   logic           slot_free;
   logic [POS_W:0] trial, trial_diff;
   logic           trial_ge;

   assign slot_free = !out_valid_ff || rsp_pop;

   // one restoring division step of the average
   assign trial = {prem_ff, quo_ff[SAMPLE_W-1]};
   assign trial_ge = (trial >= {1'b0, dvs_ff});
   assign trial_diff = trial - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      prem_in = prem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      step_in = step_ff;
      left_in = left_ff;
      last_in = last_ff;
      err_in = err_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      value_in = value_ff;
      run_end_in = run_end_ff;
      pass_end_in = pass_end_ff;
      error_in = error_ff;
      q_pop = 1'b0;

      case (state_ff)
         // take the next command
         BACK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               last_in = q_cmd.last;
               err_in = q_cmd.err;
               quo_in = q_cmd.sum[SAMPLE_W-1:0];
               if (q_cmd.avg) begin
                  prem_in = q_cmd.sum[SUM_W-1:SAMPLE_W];
                  dvs_in = q_cmd.len;
                  step_in = STEP_W'(SAMPLE_W);
                  state_in = BACK_DIV;
               end else begin
                  left_in = q_cmd.len;
                  state_in = BACK_REP;
               end
            end
         end
         // shift in one quotient bit a cycle
         BACK_DIV: begin
            prem_in = trial_ge ? trial_diff[POS_W-1:0] : trial[POS_W-1:0];
            quo_in = {quo_ff[SAMPLE_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = BACK_EMIT;
            end
         end
         // hold the average until the result slot frees
         BACK_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               value_in = quo_ff;
               run_end_in = 1'b1;
               pass_end_in = last_ff;
               error_in = 1'b0;
               state_in = BACK_IDLE;
            end
         end
         // emit one copy per free slot
         BACK_REP: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               value_in = quo_ff;
               run_end_in = (left_ff == POS_W'(1));
               pass_end_in = (left_ff == POS_W'(1)) && last_ff;
               error_in = err_ff;
               left_in = left_ff - POS_W'(1);
               if (left_ff == POS_W'(1)) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      prem_ff <= prem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      step_ff <= step_in;
      left_ff <= left_in;
      last_ff <= last_in;
      err_ff <= err_in;
      value_ff <= value_in;
      run_end_ff <= run_end_in;
      pass_end_ff <= pass_end_in;
      error_ff <= error_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_value = value_ff;
   assign rsp_run_end = run_end_ff;
   assign rsp_pass_end = pass_end_ff;
   assign rsp_error = error_ff;

endmodule
`default_nettype wire

### rtl/box_average_resampler_1d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_average_resampler_1d: one-dimensional box-average resampler
// Shrinks a sample stream by floored group averages or grows it by repeated
// copies, with exact rational group lengths and capped repeat runs.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req_      in         push / full             sample
//   rsp_      out        empty / pop             value, run_end, pass_end, error
//   csr_      in         valid / ready (=1)      index, wdata
//
// The front end takes one item per cycle while the ratio is ready and the
// two-entry command queue has room. For a shrink group the back end takes
// the command, runs its bit-serial average divider and loads the result
// register; for a grow run it takes the command and then emits one copy per
// free result slot.
// After reset and after each size write, full stays high while the 13-step
// ratio divider runs. Reset is synchronous and active high.
// The result register lets the back end finish the next average while a
// result waits to be popped.
// ----------------------------------------------------------------------------
module box_average_resampler_1d #(
   parameter int MAX_LEN = 4096,
   parameter int MAX_REPEAT = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   input  wire logic [rsmp_pkg::SAMPLE_W-1:0]       req_sample,
   output logic                                     req_full,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [rsmp_pkg::SAMPLE_W-1:0]            rsp_value,
   output logic                                     rsp_run_end,
   output logic                                     rsp_pass_end,
   output logic                                     rsp_error,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rsmp_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  wire logic [rsmp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rsmp_pkg::*;

   logic           q_push, q_pop;
   cmd_type        push_cmd, pop_cmd;
   queue_stat_type q_stat;

   assign csr_ready = 1'b1;

   // classify items and issue commands
   rsmp_front #(
      .MAX_LEN    (MAX_LEN),
      .MAX_REPEAT (MAX_REPEAT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_push   (req_push),
      .req_sample (req_sample),
      .req_full   (req_full),
      .q_full     (q_stat.full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // decouple front and back
   rsmp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .stat     (q_stat)
   );

   // divide or repeat, and hold the result
   rsmp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .q_cmd        (pop_cmd),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_value    (rsp_value),
      .rsp_run_end  (rsp_run_end),
      .rsp_pass_end (rsp_pass_end),
      .rsp_error    (rsp_error)
   );

   // the last result of a pass also closes its run
   a_pass_end_run_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pass_end) |-> rsp_run_end)
      else $error("pass_end without run_end");

   // a size write blocks items while the ratio is recomputed
   a_cfg_blocks_items: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == CSR_IN_SIZE || csr_index == CSR_OUT_SIZE))
      |=> req_full)
      else $error("item accepted during ratio update");

   // queue status is consistent
   a_queue_stat: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty at once");

   // no command is pushed into a full queue
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push)
      else $error("push into full queue");

endmodule
`default_nettype wire
